[rtl/core/fcd_pkg.sv]
`default_nettype none

package fcd_pkg;

	// field and register widths
	localparam int DIM_W  = 13;
	localparam int POS_W  = 12;
	localparam int FMT_W  = 3;
	localparam int SUM_W  = 16;
	localparam int LUMA_W = 8;
	localparam int WORD_W = 32;
	localparam int CFG_W  = 16;

	// frame dimension limits
	localparam logic [DIM_W-1:0] DIM_MIN = 13'd32;
	localparam logic [DIM_W-1:0] DIM_MAX = 13'd4096;

	// register defaults
	localparam logic [DIM_W-1:0] WIDTH_RST     = 13'd1920;
	localparam logic [DIM_W-1:0] HEIGHT_RST    = 13'd1080;
	localparam logic [SUM_W-1:0] THRESHOLD_RST = 16'd1200;

	// divide by three: (x * 683) >> 11 is exact for x up to 765
	localparam int LUMA_RECIP = 683;
	localparam int LUMA_SHIFT = 11;
	localparam int PROD_W     = 20;

	typedef enum logic [1:0] {
		CFG_FRAME_WIDTH      = 2'd0,
		CFG_FRAME_HEIGHT     = 2'd1,
		CFG_PIX_FMT          = 2'd2,
		CFG_CHANGE_THRESHOLD = 2'd3
	} cfg_reg_t;

	typedef enum logic [FMT_W-1:0] {
		FMT_RGBA8  = 3'd0,
		FMT_BGRA8  = 3'd1,
		FMT_ARGB10 = 3'd2,
		FMT_ABGR10 = 3'd3,
		FMT_NONE   = 3'd4
	} pix_fmt_t;

	// per-pixel raster status
	typedef struct packed {
		logic hit;
		logic last;
	} trk_info_t;

endpackage

`default_nettype wire

[rtl/core/fcd_pixel_if.sv]
`default_nettype none

interface fcd_pixel_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_word;

	modport source (output valid, output pixel_word, input ready);
	modport sink (input valid, input pixel_word, output ready);
endinterface

`default_nettype wire

[rtl/core/fcd_result_if.sv]
`default_nettype none

interface fcd_result_if;
	logic        valid;
	logic        ready;
	logic        change_flag;
	logic [15:0] difference_sum;

	modport source (output valid, output change_flag, output difference_sum, input ready);
	modport sink (input valid, input change_flag, input difference_sum, output ready);
endinterface

`default_nettype wire

[rtl/core/fcd_luma.sv]
`default_nettype none

module fcd_luma
	import fcd_pkg::*;
(
	input  logic [WORD_W-1:0] pixel_word,
	input  pix_fmt_t          fmt_sel,
	output logic [LUMA_W-1:0] luma
);

	logic [7:0]        r_c;
	logic [7:0]        g_c;
	logic [7:0]        b_c;
	logic [9:0]        sum_c;
	logic [PROD_W-1:0] prod_c;

	// unpack channels, 10-bit formats drop the two low bits
	always_comb begin
		r_c = '0;
		g_c = '0;
		b_c = '0;
		case (fmt_sel)
			FMT_RGBA8: begin
				r_c = pixel_word[7:0];
				g_c = pixel_word[15:8];
				b_c = pixel_word[23:16];
			end
			FMT_BGRA8: begin
				b_c = pixel_word[7:0];
				g_c = pixel_word[15:8];
				r_c = pixel_word[23:16];
			end
			FMT_ARGB10: begin
				r_c = pixel_word[29:22];
				g_c = pixel_word[19:12];
				b_c = pixel_word[9:2];
			end
			FMT_ABGR10: begin
				b_c = pixel_word[29:22];
				g_c = pixel_word[19:12];
				r_c = pixel_word[9:2];
			end
			default: begin
				r_c = '0;
				g_c = '0;
				b_c = '0;
			end
		endcase
	end

	// average the three channels
	assign sum_c  = {2'b00, r_c} + {2'b00, g_c} + {2'b00, b_c};
	assign prod_c = PROD_W'(sum_c) * PROD_W'(LUMA_RECIP);
	assign luma   = prod_c[LUMA_SHIFT +: LUMA_W];

endmodule

`default_nettype wire

[rtl/core/fcd_raster.sv]
`default_nettype none

module fcd_raster
	import fcd_pkg::*;
#(
	parameter int GRID_SIZE = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                advance,
	input  logic [DIM_W-1:0]                    frame_width,
	input  logic [DIM_W-1:0]                    frame_height,
	output trk_info_t                           info,
	output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] sample_idx
);

	localparam int IDX_W = $clog2(GRID_SIZE * GRID_SIZE);
	localparam int GC_W  = $clog2(GRID_SIZE);
	localparam int TWO_G = 2 * GRID_SIZE;
	localparam int NUM_W = $clog2(TWO_G) + DIM_W;

	logic [POS_W-1:0] col_q;
	logic [POS_W-1:0] row_q;
	logic [GC_W-1:0]  gcol_q;
	logic [GC_W-1:0]  grow_q;

	logic [DIM_W-1:0] w_c;
	logic [DIM_W-1:0] h_c;
	logic [NUM_W-1:0] col_num_c;
	logic [NUM_W-1:0] row_num_c;
	logic [NUM_W-1:0] col_lo_c;
	logic [NUM_W-1:0] row_lo_c;
	logic             col_hit_c;
	logic             row_hit_c;
	logic             col_more_c;
	logic             row_more_c;

	// saturate dimensions
	always_comb begin
		w_c = frame_width;
		if (frame_width < DIM_MIN) w_c = DIM_MIN;
		else if (frame_width > DIM_MAX) w_c = DIM_MAX;
		h_c = frame_height;
		if (frame_height < DIM_MIN) h_c = DIM_MIN;
		else if (frame_height > DIM_MAX) h_c = DIM_MAX;
	end

	// position matches (2g+1)*size / 2G when pos*2G <= num < pos*2G + 2G
	assign col_num_c = NUM_W'({gcol_q, 1'b1}) * NUM_W'(w_c);
	assign row_num_c = NUM_W'({grow_q, 1'b1}) * NUM_W'(h_c);
	assign col_lo_c  = NUM_W'(col_q) * NUM_W'(TWO_G);
	assign row_lo_c  = NUM_W'(row_q) * NUM_W'(TWO_G);
	assign col_hit_c = (col_lo_c <= col_num_c) &&
		({1'b0, col_num_c} < ({1'b0, col_lo_c} + (NUM_W+1)'(TWO_G)));
	assign row_hit_c = (row_lo_c <= row_num_c) &&
		({1'b0, row_num_c} < ({1'b0, row_lo_c} + (NUM_W+1)'(TWO_G)));

	assign col_more_c = ({1'b0, col_q} + 13'd1) < w_c;
	assign row_more_c = ({1'b0, row_q} + 13'd1) < h_c;

	assign info.hit   = col_hit_c && row_hit_c;
	assign info.last  = !col_more_c && !row_more_c;
	assign sample_idx = IDX_W'(grow_q) * IDX_W'(GRID_SIZE) + IDX_W'(gcol_q);

	// advance raster and grid position per accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			gcol_q <= '0;
			grow_q <= '0;
		end else if (advance) begin
			if (info.hit) begin
				if (gcol_q == GC_W'(GRID_SIZE - 1)) begin
					gcol_q <= '0;
					if (grow_q != GC_W'(GRID_SIZE - 1)) grow_q <= grow_q + 1'b1;
				end else begin
					gcol_q <= gcol_q + 1'b1;
				end
			end
			if (col_more_c) begin
				col_q <= col_q + 1'b1;
			end else begin
				col_q  <= '0;
				gcol_q <= '0;
				if (row_more_c) begin
					row_q <= row_q + 1'b1;
				end else begin
					row_q  <= '0;
					grow_q <= '0;
				end
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/frame_scene_change_detector_core.sv]
`default_nettype none
// Result path: a frame's last pixel request passes the input stage and then the result
//   register before its result can be taken.
// Throughput: one pixel per cycle; the input stalls only while a finished result is
//   held in the output register and the next frame's last pixel is ready to report.
// Reset: registers take their defaults, raster position clears, no signature is saved;
//   the two signature banks are not cleared.

module frame_scene_change_detector_core
	import fcd_pkg::*;
#(
	parameter int GRID_SIZE = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	fcd_pixel_if.sink          pixel,
	fcd_result_if.source       result
);

	localparam int SIG_DEPTH = GRID_SIZE * GRID_SIZE;
	localparam int IDX_W     = $clog2(SIG_DEPTH);

	// configuration registers
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	pix_fmt_t         fmt_q;
	logic [SUM_W-1:0] thr_q;

	// raster tracking
	trk_info_t        info_c;
	logic [IDX_W-1:0] idx_c;
	logic             accept_c;

	// input stage
	logic              valid_s1;
	logic              hit_s1;
	logic              last_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [WORD_W-1:0] word_s1;
	logic [LUMA_W-1:0] rd0_s1;
	logic [LUMA_W-1:0] rd1_s1;
	logic              adv_c;

	// signature storage: two banks, per-entry bank pointers
	logic [LUMA_W-1:0]    bank0_q [SIG_DEPTH];
	logic [LUMA_W-1:0]    bank1_q [SIG_DEPTH];
	logic [SIG_DEPTH-1:0] sav_q;
	logic [SIG_DEPTH-1:0] cur_q;
	logic [SIG_DEPTH-1:0] cur_nx_c;
	logic                 sig_valid_q;
	logic [SUM_W-1:0]     run_q;

	// result register
	logic             out_valid_q;
	logic             out_changed_q;
	logic [SUM_W-1:0] out_sum_q;

	// stage one datapath
	logic [LUMA_W-1:0] luma_c;
	logic [LUMA_W-1:0] saved_c;
	logic [LUMA_W-1:0] diff_c;
	logic              wbank_c;
	logic [SUM_W:0]    acc_c;
	logic [SUM_W-1:0]  total_c;
	logic              changed_c;

	// hold configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			fmt_q    <= FMT_BGRA8;
			thr_q    <= THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:      width_q  <= cfg_data[DIM_W-1:0];
				CFG_FRAME_HEIGHT:     height_q <= cfg_data[DIM_W-1:0];
				CFG_PIX_FMT:          fmt_q    <= pix_fmt_t'(cfg_data[FMT_W-1:0]);
				CFG_CHANGE_THRESHOLD: thr_q    <= cfg_data[SUM_W-1:0];
				default: ;
			endcase
		end
	end

	fcd_raster #(
		.GRID_SIZE (GRID_SIZE)
	) u_raster (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (accept_c),
		.frame_width  (width_q),
		.frame_height (height_q),
		.info         (info_c),
		.sample_idx   (idx_c)
	);

	// handshake: stage one moves on unless a frame result has nowhere to go
	assign adv_c        = valid_s1 && (!last_s1 || !out_valid_q || result.ready);
	assign pixel.ready  = !valid_s1 || adv_c;
	assign accept_c     = pixel.valid && pixel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_c) begin
			valid_s1 <= 1'b1;
		end else if (adv_c) begin
			valid_s1 <= 1'b0;
		end
	end

	// capture request payload and read both banks at the sample index
	always_ff @(posedge clk) begin
		if (accept_c) begin
			hit_s1  <= info_c.hit;
			last_s1 <= info_c.last;
			idx_s1  <= idx_c;
			word_s1 <= pixel.pixel_word;
			rd0_s1  <= bank0_q[idx_c];
			rd1_s1  <= bank1_q[idx_c];
		end
		if (adv_c && hit_s1 && !wbank_c) bank0_q[idx_s1] <= luma_c;
		if (adv_c && hit_s1 && wbank_c) bank1_q[idx_s1] <= luma_c;
	end

	fcd_luma u_luma (
		.pixel_word (word_s1),
		.fmt_sel    (fmt_q),
		.luma       (luma_c)
	);

	// compare with saved entry and accumulate
	assign saved_c   = sav_q[idx_s1] ? rd1_s1 : rd0_s1;
	assign wbank_c   = !sav_q[idx_s1];
	assign diff_c    = (luma_c >= saved_c) ? (luma_c - saved_c) : (saved_c - luma_c);
	assign acc_c     = {1'b0, run_q} +
		((hit_s1 && sig_valid_q) ? (SUM_W+1)'(diff_c) : '0);
	assign total_c   = acc_c[SUM_W] ? '1 : acc_c[SUM_W-1:0];
	assign changed_c = !sig_valid_q || (total_c >= thr_q);

	// candidate entry now lives in the write bank
	always_comb begin
		cur_nx_c = cur_q;
		if (hit_s1) cur_nx_c[idx_s1] = wbank_c;
	end

	// update running sum and signature pointers; promote candidate on change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sav_q       <= '0;
			cur_q       <= '0;
			sig_valid_q <= 1'b0;
			run_q       <= '0;
		end else if (adv_c) begin
			cur_q <= cur_nx_c;
			if (last_s1) begin
				run_q <= '0;
				if (changed_c) begin
					sav_q       <= cur_nx_c;
					sig_valid_q <= 1'b1;
				end
			end else begin
				run_q <= total_c;
			end
		end
	end

	// hold frame result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_c && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_c && last_s1) begin
			out_changed_q <= changed_c;
			out_sum_q     <= sig_valid_q ? total_c : '0;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.change_flag    = out_changed_q;
	assign result.difference_sum = out_sum_q;

`ifndef SYNTH
	// a pending frame result blocks new requests while the next frame's last pixel waits in stage one
	a_stall_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && out_valid_q && !result.ready) |-> !pixel.ready)
		else $error("request accepted while frame result blocked");

	// a reported change leaves a saved signature
	a_change_saves: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_c && last_s1 && changed_c) |=> sig_valid_q)
		else $error("signature not saved after change");

	// no-change can only follow a saved signature
	a_nochange_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.change_flag) |-> sig_valid_q)
		else $error("no-change reported without saved signature");
`endif

endmodule

`default_nettype wire

[bench/frame_scene_change_detector_core_tb.sv]
`default_nettype none

module frame_scene_change_detector_core_tb
	import fcd_pkg::*;
();

	localparam int GRID          = 16;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_FRAMES = 44;
	localparam int CALM_FRAMES   = 6;

	typedef enum int {
		SCENE_NOISE,
		SCENE_NEW,
		SCENE_SAME,
		SCENE_JITTER,
		SCENE_FLAT
	} scene_kind_t;

	// Luma signature tracker: follows the raster, builds the candidate signature
	// and queues the report expected at the end of each frame.
	class frame_sig_scoreboard;
		typedef struct {
			logic        changed;
			logic [15:0] diff_total;
		} report_t;

		logic [DIM_W-1:0]  width_reg;
		logic [DIM_W-1:0]  height_reg;
		logic [FMT_W-1:0]  format_reg;
		logic [SUM_W-1:0]  threshold_reg;
		logic [LUMA_W-1:0] saved_sig [GRID*GRID];
		logic [LUMA_W-1:0] cand_sig [GRID*GRID];
		bit                have_sig;
		int unsigned       diff_acc;
		int unsigned       col;
		int unsigned       row;
		int unsigned       gcol;
		int unsigned       grow;
		report_t           pending_reports[$];
		int unsigned       frames_seen;
		int unsigned       changes_seen;
		int unsigned       pixels_seen;
		int unsigned       error_count;

		function new();
			width_reg     = WIDTH_RST;
			height_reg    = HEIGHT_RST;
			format_reg    = FMT_BGRA8;
			threshold_reg = THRESHOLD_RST;
			foreach (saved_sig[i]) begin
				saved_sig[i] = '0;
				cand_sig[i]  = '0;
			end
			have_sig     = 1'b0;
			diff_acc     = 0;
			col          = 0;
			row          = 0;
			gcol         = 0;
			grow         = 0;
			frames_seen  = 0;
			changes_seen = 0;
			pixels_seen  = 0;
			error_count  = 0;
		endfunction

		function int unsigned clamp_dim(logic [DIM_W-1:0] v);
			if (v < DIM_MIN)
				return DIM_MIN;
			if (v > DIM_MAX)
				return DIM_MAX;
			return v;
		endfunction

		function int unsigned eff_width();
			return clamp_dim(width_reg);
		endfunction

		function int unsigned eff_height();
			return clamp_dim(height_reg);
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
			case (idx)
				CFG_FRAME_WIDTH:      width_reg = data[DIM_W-1:0];
				CFG_FRAME_HEIGHT:     height_reg = data[DIM_W-1:0];
				CFG_PIX_FMT:          format_reg = data[FMT_W-1:0];
				CFG_CHANGE_THRESHOLD: threshold_reg = data[SUM_W-1:0];
				default: ;
			endcase
		endfunction

		// 10-bit channels keep their top 8 bits; unknown formats read as black
		function logic [LUMA_W-1:0] luma_of(logic [31:0] w);
			logic [9:0] r;
			logic [9:0] g;
			logic [9:0] b;
			r = '0;
			g = '0;
			b = '0;
			case (format_reg)
				FMT_RGBA8: begin
					r = w[7:0];
					g = w[15:8];
					b = w[23:16];
				end
				FMT_BGRA8: begin
					b = w[7:0];
					g = w[15:8];
					r = w[23:16];
				end
				FMT_ARGB10: begin
					r = w[29:22];
					g = w[19:12];
					b = w[9:2];
				end
				FMT_ABGR10: begin
					b = w[29:22];
					g = w[19:12];
					r = w[9:2];
				end
				default: ;
			endcase
			return LUMA_W'((r + g + b) / 3);
		endfunction

		function int unsigned sample_at(int unsigned g, int unsigned size);
			return ((2 * g + 1) * size) / (2 * GRID);
		endfunction

		function void note_pixel(logic [31:0] w);
			int unsigned fw;
			int unsigned fh;
			int unsigned idx;
			int unsigned l;
			int unsigned s;
			report_t     rep;
			fw = eff_width();
			fh = eff_height();
			pixels_seen++;

			// take the sample and accumulate its distance to the saved signature
			if (grow < GRID && gcol < GRID && row == sample_at(grow, fh) &&
			    col == sample_at(gcol, fw)) begin
				idx = grow * GRID + gcol;
				l = luma_of(w);
				cand_sig[idx] = LUMA_W'(l);
				if (have_sig) begin
					s = saved_sig[idx];
					diff_acc += (l >= s) ? l - s : s - l;
					if (diff_acc > 65535)
						diff_acc = 65535;
				end
				if (gcol >= GRID - 1) begin
					gcol = 0;
					if (grow < GRID - 1)
						grow++;
				end else begin
					gcol++;
				end
			end

			// advance the raster
			if (col + 1 < fw) begin
				col++;
				return;
			end
			col  = 0;
			gcol = 0;
			if (row + 1 < fh) begin
				row++;
				return;
			end

			// end of frame: decide and queue the report
			rep.changed    = !have_sig || diff_acc >= threshold_reg;
			rep.diff_total = have_sig ? diff_acc[15:0] : 16'd0;
			if (rep.changed) begin
				saved_sig = cand_sig;
				have_sig  = 1'b1;
				changes_seen++;
			end
			pending_reports.push_back(rep);
			frames_seen++;
			diff_acc = 0;
			row      = 0;
			grow     = 0;
		endfunction

		function void check_report(logic changed, logic [15:0] diff_total);
			report_t exp_rep;
			if (pending_reports.size() == 0) begin
				$error("unexpected result: change_flag=%0b difference_sum=%0d",
				       changed, diff_total);
				error_count++;
				return;
			end
			exp_rep = pending_reports.pop_front();
			if (changed !== exp_rep.changed) begin
				$error("change_flag: expected %0b, actual %0b", exp_rep.changed, changed);
				error_count++;
			end
			if (diff_total !== exp_rep.diff_total) begin
				$error("difference_sum: expected %0d, actual %0d",
				       exp_rep.diff_total, diff_total);
				error_count++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	cfg_reg_t         cfg_index;
	logic [CFG_W-1:0] cfg_data;
	bit               src_gaps;
	bit               sink_stalls;
	int unsigned      stall_left = 0;
	logic [31:0]      scene_seed;

	frame_sig_scoreboard sb;

	fcd_pixel_if  pixel ();
	fcd_result_if result ();

	frame_scene_change_detector_core #(
		.GRID_SIZE(GRID)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pixel    (pixel),
		.result   (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(8 * 3_000_000);
		$display("frame_scene_change_detector_core regression: fail");
		$finish;
	end

	// Track config writes, accepted pixels and accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.write_reg(cfg_index, cfg_data);
			if (pixel.valid && pixel.ready)
				sb.note_pixel(pixel.pixel_word);
			if (result.valid && result.ready)
				sb.check_report(result.change_flag, result.difference_sum);
		end
	end

	// Drop result ready in short random bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left   <= stall_left - 1;
			result.ready <= (stall_left == 1);
		end else if (sink_stalls && $urandom_range(0, 2) == 0) begin
			stall_left   <= $urandom_range(1, 3);
			result.ready <= 1'b0;
		end else begin
			result.ready <= 1'b1;
		end
	end

	function automatic logic [31:0] scene_word(logic [31:0] seed, int unsigned x,
	                                           int unsigned y);
		logic [31:0] h;
		h = seed ^ (x * 32'h9E37_79B1) ^ (y * 32'h85EB_CA77);
		h = h ^ (h >> 15);
		h = h * 32'h2C1B_3C6D;
		h = h ^ (h >> 12);
		return h;
	endfunction

	task automatic send_pixel(input logic [31:0] w);
		if (src_gaps && $urandom_range(0, 7) == 0) begin
			pixel.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		pixel.valid      <= 1'b1;
		pixel.pixel_word <= w;
		do @(posedge clk); while (!pixel.ready);
	endtask

	task automatic send_frame(input scene_kind_t kind, input logic [31:0] flat_word);
		int unsigned fw;
		int unsigned fh;
		logic [31:0] jitter;
		logic [31:0] n;
		logic [31:0] w;
		fw = sb.eff_width();
		fh = sb.eff_height();
		n = (32'd1 << $urandom_range(1, 5)) - 1;
		jitter = (n * 32'h0101_0101) | (n * 32'h0010_0401);
		if (kind == SCENE_NEW)
			scene_seed = $urandom;
		for (int unsigned y = 0; y < fh; y++) begin
			for (int unsigned x = 0; x < fw; x++) begin
				case (kind)
					SCENE_NOISE:  w = $urandom;
					SCENE_JITTER: w = scene_word(scene_seed, x, y) ^ ($urandom & jitter);
					SCENE_FLAT:   w = flat_word;
					default:      w = scene_word(scene_seed, x, y);
				endcase
				send_pixel(w);
			end
		end
	endtask

	// Hold pixels off until every report is in and the pipeline has emptied
	task automatic drain();
		pixel.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Width and height go first so the frame size is known once this returns
	task automatic setup_regs(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
	                          input logic [CFG_W-1:0] fmt, input logic [CFG_W-1:0] thr);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_FRAME_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= CFG_FRAME_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_index <= CFG_PIX_FMT;
		cfg_data  <= fmt;
		@(posedge clk);
		cfg_index <= CFG_CHANGE_THRESHOLD;
		cfg_data  <= thr;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [CFG_W-1:0] pick_dim();
		int unsigned r;
		logic [DIM_W-1:0] d;
		r = $urandom_range(0, 15);
		if (r == 0)
			d = DIM_W'($urandom_range(0, 31));
		else if (r == 1)
			d = DIM_W'($urandom_range(65, 160));
		else
			d = DIM_W'($urandom_range(32, 64));
		return {3'($urandom_range(0, 7)), d};
	endfunction

	function automatic logic [CFG_W-1:0] pick_format();
		logic [FMT_W-1:0] f;
		if ($urandom_range(0, 4) == 0)
			f = FMT_W'($urandom_range(4, 7));
		else
			f = FMT_W'($urandom_range(0, 3));
		return {13'($urandom), f};
	endfunction

	function automatic logic [CFG_W-1:0] pick_threshold();
		case ($urandom_range(0, 7))
			0:       return 16'd0;
			1:       return 16'hFFFF;
			2:       return 16'($urandom);
			default: return 16'($urandom_range(0, 4000));
		endcase
	endfunction

	initial begin
		int unsigned r;
		scene_kind_t kind;

		sb               = new();
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = CFG_FRAME_WIDTH;
		cfg_data         = '0;
		pixel.valid      = 1'b0;
		pixel.pixel_word = '0;
		src_gaps         = 1'b1;
		sink_stalls      = 1'b1;
		scene_seed       = $urandom;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first frame always changes with zero sum; then full-scale swing at threshold zero
		setup_regs(16'd32, 16'd32, FMT_RGBA8, 16'd0);
		send_frame(SCENE_FLAT, 32'h0000_0000);
		send_frame(SCENE_FLAT, 32'hFFFF_FFFF);

		// threshold above the largest sum: signature stays put
		setup_regs(16'd32, 16'd32, FMT_BGRA8, 16'hFFFF);
		send_frame(SCENE_FLAT, 32'h0000_0000);
		send_frame(SCENE_FLAT, 32'hFFFF_FFFF);

		// undersized dims saturate; largest sum meets threshold exactly
		setup_regs(16'd0, 16'd31, FMT_ARGB10, 16'd65280);
		send_frame(SCENE_FLAT, 32'h0000_0000);

		// identical scene stays below threshold one, jitter may cross it
		setup_regs(16'd33, 16'd47, FMT_ABGR10, 16'd1);
		send_frame(SCENE_NEW, '0);
		send_frame(SCENE_SAME, '0);
		send_frame(SCENE_JITTER, '0);

		// unsupported formats decode to black
		setup_regs(16'd40, 16'd32, FMT_NONE, 16'd0);
		send_frame(SCENE_NOISE, '0);
		setup_regs(16'd32, 16'd36, 16'hFFFD, 16'd100);
		send_frame(SCENE_NOISE, '0);
		setup_regs(16'd34, 16'd32, 16'h0006, 16'd100);
		send_frame(SCENE_NOISE, '0);
		setup_regs(16'd32, 16'd32, 16'hFFFF, 16'd100);
		send_frame(SCENE_NOISE, '0);

		// widest and tallest frames, oversized width saturates
		setup_regs(16'hFFFF, 16'd32, FMT_RGBA8, 16'd2000);
		send_frame(SCENE_NEW, '0);
		setup_regs(16'd32, 16'd4096, FMT_ARGB10, 16'd2000);
		send_frame(SCENE_NOISE, '0);

		// random settings and scenes; calm stretch at the end
		for (int f = 0; f < RANDOM_FRAMES; f++) begin
			if (f >= RANDOM_FRAMES - CALM_FRAMES) begin
				src_gaps    = 1'b0;
				sink_stalls <= 1'b0;
			end else begin
				src_gaps    = ($urandom_range(0, 3) != 0);
				sink_stalls <= ($urandom_range(0, 3) != 0);
			end
			if (f == 0 || $urandom_range(0, 1) == 0)
				setup_regs(pick_dim(), pick_dim(), pick_format(), pick_threshold());
			r = $urandom_range(0, 9);
			if (r < 2)
				kind = SCENE_NOISE;
			else if (r < 3)
				kind = SCENE_NEW;
			else if (r < 5)
				kind = SCENE_SAME;
			else if (r < 9)
				kind = SCENE_JITTER;
			else
				kind = SCENE_FLAT;
			send_frame(kind, $urandom);
		end

		drain();
		$display("checked %0d frame reports (%0d scene changes) over %0d pixels",
		         sb.frames_seen, sb.changes_seen, sb.pixels_seen);
		$display("all pixel formats, thresholds 0..65535, frames 32x32 up to 4096 wide or tall");
		if (sb.error_count == 0)
			$display("frame_scene_change_detector_core regression: pass");
		else
			$display("frame_scene_change_detector_core regression: fail");
		$finish;
	end

endmodule

`default_nettype wire

[filelist.f]
rtl/core/fcd_pkg.sv
rtl/core/fcd_pixel_if.sv
rtl/core/fcd_result_if.sv
rtl/core/fcd_luma.sv
rtl/core/fcd_raster.sv
rtl/core/frame_scene_change_detector_core.sv
bench/frame_scene_change_detector_core_tb.sv
